/* sv/psw_pkg.sv */
package psw_pkg;

    // Distance datapath widths.
    localparam int PIX_W  = 8;
    localparam int MAG_W  = 33;
    localparam int MZ_W   = 32;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int SUM_W  = 68;
    localparam int FRAC_SHIFT = 30;

    // Square root: one result bit per pipeline stage.
    localparam int ROOT_W = 50;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;

    // Phase multiply, split into 25 x 32 partial products.
    localparam int RLO_W  = 25;
    localparam int KLO_W  = 32;
    localparam int PP_W   = RLO_W + KLO_W;
    localparam int ACC_W  = 80;
    localparam int PHASE_W = 16;
    localparam logic [63:0] INV_TWO_PI = 64'h28BE60DB9391054A;

    // Quarter-wave polynomial in Q30.
    localparam int Q_W    = 31;
    localparam int P_W    = 62;
    localparam int M_W    = 15;
    localparam int OUT_W  = 16;
    localparam logic [M_W-1:0] QUARTER = 15'd16384;
    localparam logic [Q_W-1:0] SIN_A1 = 31'd1686629713;
    localparam logic [Q_W-1:0] SIN_A3 = 31'd693598668;
    localparam logic [Q_W-1:0] SIN_A5 = 31'd85569306;
    localparam logic [Q_W-1:0] SIN_A7 = 31'd5026995;
    localparam logic [Q_W-1:0] SIN_A9 = 31'd172272;
    localparam logic [M_W-1:0] Q_MAX  = 15'd32767;

    localparam logic [30:0] SOURCE_Z_RESET = 31'd5000000;

    typedef enum logic [1:0] {
        REG_SOURCE_X     = 2'd0,
        REG_SOURCE_Y     = 2'd1,
        REG_SOURCE_Z     = 2'd2,
        REG_PHASE_OFFSET = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic signed [31:0] source_x;
        logic signed [31:0] source_y;
        logic [30:0]        source_z;
        logic [15:0]        phase_offset;
    } cfg_t;

    // Horner coefficient used by polynomial stage j (stages 2 to 5).
    function automatic logic [Q_W-1:0] horner_coef(input int j);
        logic [Q_W-1:0] c;
        case (j)
            2:       c = SIN_A7;
            3:       c = SIN_A5;
            4:       c = SIN_A3;
            default: c = SIN_A1;
        endcase
        return c;
    endfunction

endpackage

/* sv/psw_dist.sv */
module psw_dist (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic signed [7:0]         pixel_x,
    input  logic signed [7:0]         pixel_y,
    input  psw_pkg::cfg_t             cfg,
    output logic                      sum_valid,
    output logic [psw_pkg::SUM_W-1:0] sum
);
    import psw_pkg::*;

    logic signed [34:0] px_ext, py_ext, sx2, sy2, dx, dy;
    logic [MAG_W-1:0] mx_next, my_next, mx_reg, my_reg;
    logic [MZ_W-1:0]  mz_next, mz_reg;
    logic [SQ_W-1:0]  sqx_reg, sqy_reg, sqz_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [2:0]       vld_reg;

    // Offsets doubled so that the 2.5 scale stays an integer.
    always_comb
    begin
        px_ext  = 35'(pixel_x);
        py_ext  = 35'(pixel_y);
        sx2     = 35'(cfg.source_x) <<< 1;
        sy2     = 35'(cfg.source_y) <<< 1;
        dx      = (px_ext <<< 2) + px_ext - sx2;
        dy      = (py_ext <<< 2) + py_ext - sy2;
        mx_next = dx[34] ? MAG_W'(-dx) : MAG_W'(dx);
        my_next = dy[34] ? MAG_W'(-dy) : MAG_W'(dy);
        mz_next = {cfg.source_z, 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg  <= mx_next;
            my_reg  <= my_next;
            mz_reg  <= mz_next;
            sqx_reg <= {{MAG_W{1'b0}}, mx_reg} * {{MAG_W{1'b0}}, mx_reg};
            sqy_reg <= {{MAG_W{1'b0}}, my_reg} * {{MAG_W{1'b0}}, my_reg};
            sqz_reg <= SQ_W'(mz_reg) * SQ_W'(mz_reg);
            sum_reg <= SUM_W'(sqx_reg) + SUM_W'(sqy_reg) + SUM_W'(sqz_reg);
        end
    end

    assign sum_valid = vld_reg[2];
    assign sum       = sum_reg;

endmodule

/* sv/psw_sqrt.sv */
module psw_sqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       sum_valid,
    input  logic [psw_pkg::SUM_W-1:0]  sum,
    output logic                       root_valid,
    output logic [psw_pkg::ROOT_W-1:0] root
);
    import psw_pkg::*;

    logic [RAD_W-1:0]  rad_in    [ROOT_W];
    logic [REM_W-1:0]  rem_in    [ROOT_W];
    logic [ROOT_W-1:0] root_in   [ROOT_W];
    logic [RAD_W-1:0]  rad_next  [ROOT_W];
    logic [REM_W-1:0]  rem_next  [ROOT_W];
    logic [ROOT_W-1:0] root_next [ROOT_W];
    logic [RAD_W-1:0]  rad_reg   [ROOT_W];
    logic [REM_W-1:0]  rem_reg   [ROOT_W];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];
    logic [ROOT_W-1:0] vld_reg;

    // Restoring square root, one result bit per stage, most significant first.
    always_comb
    begin
        logic [REM_W+1:0] cur;
        logic [REM_W+1:0] trial;
        rad_in[0]  = RAD_W'({sum, {FRAC_SHIFT{1'b0}}});
        rem_in[0]  = '0;
        root_in[0] = '0;
        for (int k = 1; k < ROOT_W; k++)
        begin
            rad_in[k]  = rad_reg[k-1];
            rem_in[k]  = rem_reg[k-1];
            root_in[k] = root_reg[k-1];
        end
        for (int k = 0; k < ROOT_W; k++)
        begin
            cur   = {rem_in[k], rad_in[k][RAD_W-1 -: 2]};
            trial = {2'b00, root_in[k], 2'b01};
            if (cur >= trial)
            begin
                rem_next[k]  = REM_W'(cur - trial);
                root_next[k] = {root_in[k][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = REM_W'(cur);
                root_next[k] = {root_in[k][ROOT_W-2:0], 1'b0};
            end
            rad_next[k] = rad_in[k] << 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[ROOT_W-2:0], sum_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < ROOT_W; k++)
            begin
                rad_reg[k]  <= rad_next[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
            end
        end
    end

    assign root_valid = vld_reg[ROOT_W-1];
    assign root       = root_reg[ROOT_W-1];

endmodule

/* sv/psw_phase.sv */
module psw_phase (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        root_valid,
    input  logic [psw_pkg::ROOT_W-1:0]  root,
    input  logic [15:0]                 phase_offset,
    output logic                        phase_valid,
    output logic [psw_pkg::PHASE_W-1:0] phase
);
    import psw_pkg::*;

    logic [PP_W-1:0]    p00_reg, p01_reg, p10_reg, p11_reg;
    logic [ACC_W-1:0]   lo_reg, hi_reg;
    logic [PHASE_W-1:0] raw_reg, phase_reg;
    logic [3:0]         vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[2:0], root_valid};
        end
    end

    // Only bits 79:64 of root * (1 / 2pi) are needed, so the sums stop at 80 bits.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p00_reg <= PP_W'(root[RLO_W-1:0]) * PP_W'(INV_TWO_PI[KLO_W-1:0]);
            p01_reg <= PP_W'(root[RLO_W-1:0]) * PP_W'(INV_TWO_PI[63:KLO_W]);
            p10_reg <= PP_W'(root[ROOT_W-1:RLO_W]) * PP_W'(INV_TWO_PI[KLO_W-1:0]);
            p11_reg <= PP_W'(root[ROOT_W-1:RLO_W]) * PP_W'(INV_TWO_PI[63:KLO_W]);
            lo_reg  <= ACC_W'(p00_reg) + (ACC_W'(p10_reg) << RLO_W);
            hi_reg  <= (ACC_W'(p01_reg) << KLO_W) + (ACC_W'(p11_reg) << (RLO_W + KLO_W));
            raw_reg <= PHASE_W'((lo_reg + hi_reg) >> 64);
            phase_reg <= raw_reg + phase_offset;
        end
    end

    assign phase_valid = vld_reg[3];
    assign phase       = phase_reg;

endmodule

/* sv/psw_sine.sv */
module psw_sine (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        phase_valid,
    input  logic [psw_pkg::PHASE_W-1:0] phase,
    output logic                        wave_valid,
    output logic signed [15:0]          field_sine,
    output logic signed [15:0]          field_cosine
);
    import psw_pkg::*;

    logic [M_W-1:0]   qval [2];
    logic [1:0]       quad_reg [7];
    logic [7:0]       vld_reg;
    logic [OUT_W-1:0] sin_reg, cos_reg;
    logic [OUT_W-1:0] pos_a, pos_b, neg_a, neg_b;

    // Lane 0 evaluates the quarter wave at r, lane 1 at one quarter turn minus r.
    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        logic [M_W-1:0] m;
        logic [Q_W-1:0] u0;
        logic [Q_W-1:0] t_w [2:5];
        logic [Q_W-1:0] u_reg  [5];
        logic [Q_W-1:0] u2_reg [1:4];
        logic [P_W-1:0] p_reg  [6];
        logic [32:0]    rnd;
        logic [M_W-1:0] q_reg;

        always_comb
        begin
            if (l == 0)
            begin
                m = {1'b0, phase[13:0]};
            end
            else
            begin
                m = QUARTER - {1'b0, phase[13:0]};
            end
            u0 = {m, 16'd0};
            for (int j = 2; j < 6; j++)
            begin
                t_w[j] = horner_coef(j) - p_reg[j-1][Q_W+29:30];
            end
            rnd = 33'(p_reg[5][P_W-1:30]) + 33'd16384;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                u_reg[0]  <= u0;
                p_reg[0]  <= P_W'(u0) * P_W'(u0);
                u_reg[1]  <= u_reg[0];
                u2_reg[1] <= p_reg[0][Q_W+29:30];
                p_reg[1]  <= P_W'(p_reg[0][Q_W+29:30]) * P_W'(SIN_A9);
                for (int j = 2; j < 5; j++)
                begin
                    u_reg[j]  <= u_reg[j-1];
                    u2_reg[j] <= u2_reg[j-1];
                    p_reg[j]  <= P_W'(u2_reg[j-1]) * P_W'(t_w[j]);
                end
                p_reg[5] <= P_W'(u_reg[4]) * P_W'(t_w[5]);
                if (rnd[32:15] > 18'(Q_MAX))
                begin
                    q_reg <= Q_MAX;
                end
                else
                begin
                    q_reg <= rnd[29:15];
                end
            end
        end

        assign qval[l] = q_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[6:0], phase_valid};
        end
    end

    always_comb
    begin
        pos_a = {1'b0, qval[0]};
        pos_b = {1'b0, qval[1]};
        neg_a = OUT_W'(0) - pos_a;
        neg_b = OUT_W'(0) - pos_b;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quad_reg[0] <= phase[15:14];
            for (int k = 1; k < 7; k++)
            begin
                quad_reg[k] <= quad_reg[k-1];
            end
            case (quad_reg[6])
                2'd0:
                begin
                    sin_reg <= pos_a;
                    cos_reg <= pos_b;
                end
                2'd1:
                begin
                    sin_reg <= pos_b;
                    cos_reg <= neg_a;
                end
                2'd2:
                begin
                    sin_reg <= neg_a;
                    cos_reg <= neg_b;
                end
                default:
                begin
                    sin_reg <= neg_b;
                    cos_reg <= pos_a;
                end
            endcase
        end
    end

    assign wave_valid   = vld_reg[7];
    assign field_sine   = sin_reg;
    assign field_cosine = cos_reg;

endmodule

/* sv/point_source_wave_field.sv */
// Throughput: one item per cycle, except while the output is stalled.
// The 50-stage bit-per-stage square root sets the depth of the pipeline.
// The whole pipeline advances together whenever the output register is empty or taken.
// Reset (rst_n low, asynchronous) clears all valid bits and loads the source registers
// with x = 0, y = 0, z = 5000000 and a phase offset of 0.
module point_source_wave_field (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [7:0]  pixel_x,
    input  logic signed [7:0]  pixel_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] field_sine,
    output logic signed [15:0] field_cosine
);
    import psw_pkg::*;

    cfg_t               cfg_reg;
    logic               adv;
    logic               sum_valid, root_valid, phase_valid;
    logic [SUM_W-1:0]   sum;
    logic [ROOT_W-1:0]  root;
    logic [PHASE_W-1:0] phase;

    // Configuration registers. The user must write them only while the pipeline is empty, so every
    // stage sees a stable source position and offset; the block itself does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_x     <= '0;
            cfg_reg.source_y     <= '0;
            cfg_reg.source_z     <= SOURCE_Z_RESET;
            cfg_reg.phase_offset <= '0;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_SOURCE_X:     cfg_reg.source_x     <= cfg_data;
                REG_SOURCE_Y:     cfg_reg.source_y     <= cfg_data;
                REG_SOURCE_Z:     cfg_reg.source_z     <= cfg_data[30:0];
                REG_PHASE_OFFSET: cfg_reg.phase_offset <= cfg_data[15:0];
                default:          ;
            endcase
        end
    end

    // Every stage moves when the output register is free or being read. A stall
    // freezes all stages at once, so nothing is dropped or duplicated.
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    // Doubled offsets, their squares and the exact sum of squares.
    psw_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (in_valid),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .cfg       (cfg_reg),
        .sum_valid (sum_valid),
        .sum       (sum)
    );

    // Distance with 16 fractional bits, one root bit per stage.
    psw_sqrt u_sqrt (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .sum_valid  (sum_valid),
        .sum        (sum),
        .root_valid (root_valid),
        .root       (root)
    );

    // Distance over 2pi as a 16-bit fraction of a turn, plus the offset.
    psw_phase u_phase (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (adv),
        .root_valid   (root_valid),
        .root         (root),
        .phase_offset (cfg_reg.phase_offset),
        .phase_valid  (phase_valid),
        .phase        (phase)
    );

    // Sine and cosine from two quarter-wave polynomials; the last stage is
    // the output register.
    psw_sine u_sine (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (adv),
        .phase_valid  (phase_valid),
        .phase        (phase),
        .wave_valid   (out_valid),
        .field_sine   (field_sine),
        .field_cosine (field_cosine)
    );

endmodule

/* test/point_source_wave_field_tb.sv */
`timescale 1ns / 100ps

module point_source_wave_field_tb;

    import psw_pkg::*;

    // Keeps its own copy of the source registers and predicts the wave value of every
    // accepted pixel, then checks the output items against those predictions in order.
    class wave_scoreboard;
        typedef struct {
            logic [15:0] sine;
            logic [15:0] cosine;
        } field_t;

        logic signed [31:0] src_x;
        logic signed [31:0] src_y;
        logic [30:0]        src_z;
        logic [15:0]        ofs;
        field_t             pending[$];
        int                 errors;

        function new();
            src_x  = 0;
            src_y  = 0;
            src_z  = SOURCE_Z_RESET;
            ofs    = 0;
            errors = 0;
        endfunction

        function void write_reg(reg_index_t idx, logic [31:0] data);
            case (idx)
                REG_SOURCE_X:     src_x = data;
                REG_SOURCE_Y:     src_y = data;
                REG_SOURCE_Z:     src_z = data[30:0];
                REG_PHASE_OFFSET: ofs = data[15:0];
                default:          ;
            endcase
        endfunction

        // Quarter-wave sine by Horner in Q30, rounded to Q1.15 and held below one.
        function logic [15:0] quarter_sine(logic [14:0] m);
            logic [63:0] u, u2, t, s;
            u  = 64'(m) << 16;
            u2 = (u * u) >> 30;
            t  = 64'(SIN_A7) - ((u2 * 64'(SIN_A9)) >> 30);
            t  = 64'(SIN_A5) - ((u2 * t) >> 30);
            t  = 64'(SIN_A3) - ((u2 * t) >> 30);
            t  = 64'(SIN_A1) - ((u2 * t) >> 30);
            s  = (u * t) >> 30;
            s  = (s + 64'd16384) >> 15;
            if (s > 64'd32767)
                s = 64'd32767;
            return s[15:0];
        endfunction

        function void note_pixel(logic signed [7:0] px, logic signed [7:0] py);
            logic signed [35:0] ex, ey;
            logic [35:0]        mx, my, mz;
            logic [67:0]        sum;
            logic [99:0]        tgt, sq;
            logic [49:0]        root, cand;
            logic [113:0]       prod;
            logic [15:0]        ph, qa, qb;
            logic [14:0]        r;
            field_t             f;
            ex  = px * 36'sd5 - src_x * 36'sd2;
            ey  = py * 36'sd5 - src_y * 36'sd2;
            mx  = ex < 0 ? -ex : ex;
            my  = ey < 0 ? -ey : ey;
            mz  = 36'(src_z) * 36'd2;
            sum = 68'(mx) * 68'(mx) + 68'(my) * 68'(my) + 68'(mz) * 68'(mz);
            tgt = 100'(sum) << 30;
            // Exact integer square root, one bit at a time from the top.
            root = '0;
            for (int b = 49; b >= 0; b--) begin
                cand = root | (50'd1 << b);
                sq   = 100'(cand) * 100'(cand);
                if (sq <= tgt)
                    root = cand;
            end
            prod = 114'(root) * 114'(INV_TWO_PI);
            ph   = prod[79:64] + ofs;
            r    = {1'b0, ph[13:0]};
            qa   = quarter_sine(r);
            qb   = quarter_sine(QUARTER - r);
            case (ph[15:14])
                2'd0:    begin f.sine = qa;  f.cosine = qb;  end
                2'd1:    begin f.sine = qb;  f.cosine = -qa; end
                2'd2:    begin f.sine = -qa; f.cosine = -qb; end
                default: begin f.sine = -qb; f.cosine = qa;  end
            endcase
            pending = {pending, f};
        endfunction

        function void check_field(logic [15:0] sine, logic [15:0] cosine);
            field_t f;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected item: sine %0d cosine %0d",
                             $signed(sine), $signed(cosine));
                return;
            end
            f = pending.pop_front();
            if (f.sine !== sine || f.cosine !== cosine) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: sine exp %0d got %0d, cosine exp %0d got %0d",
                             $signed(f.sine), $signed(sine), $signed(f.cosine),
                             $signed(cosine));
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 400000;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic signed [7:0]  pixel_x;
    logic signed [7:0]  pixel_y;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] field_sine;
    logic signed [15:0] field_cosine;

    wave_scoreboard wave_sb;
    int             cycles;
    logic           hold_go;
    logic           holding;

    point_source_wave_field uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .field_sine   (field_sine),
        .field_cosine (field_cosine)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // A run that stops making progress is cut off here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Every item that leaves the block is checked at the edge where it is taken.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            wave_sb.check_field(field_sine, field_cosine);
    end

    // The receiver runs through stall patterns of its own: always ready, random
    // stalls, and rare stalls. A long hold-off lets the pipeline fill up.
    always @(negedge clk)
    begin
        if (holding)
            out_ready <= 1'b0;
        else
            case ((cycles / 97) % 3)
                0:       out_ready <= 1'b1;
                1:       out_ready <= 1'($urandom_range(0, 1));
                default: out_ready <= ($urandom_range(0, 7) != 0);
            endcase
    end

    initial
    begin
        holding = 1'b0;
        wait (hold_go);
        holding = 1'b1;
        repeat (300) @(negedge clk);
        holding = 1'b0;
    end

    // Offers one pixel and waits until it is accepted. The valid stays high after
    // acceptance, so consecutive calls form a burst.
    task automatic send_pixel(logic [7:0] px, logic [7:0] py);
        @(negedge clk);
        in_valid = 1'b1;
        pixel_x  = px;
        pixel_y  = py;
        do
            @(posedge clk);
        while (!in_ready);
        wave_sb.note_pixel(pixel_x, pixel_y);
    endtask

    task automatic end_burst(int gap);
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
    endtask

    // Waits until every accepted item has come out again.
    task automatic wait_drained();
        while (wave_sb.pending.size() != 0)
            @(posedge clk);
    endtask

    // Register writes happen only while nothing is in flight.
    task automatic write_reg(reg_index_t idx, logic [31:0] data);
        wait_drained();
        repeat (2) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        wave_sb.write_reg(idx, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_source(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic [31:0] offset);
        write_reg(REG_SOURCE_X, x);
        write_reg(REG_SOURCE_Y, y);
        write_reg(REG_SOURCE_Z, z);
        write_reg(REG_PHASE_OFFSET, offset);
    endtask

    // Random pixels in bursts of random length, with a random gap after each burst.
    task automatic random_pixels(int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && sent < count; i++) begin
                send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                sent++;
            end
            end_burst(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
        end
    endtask

    initial
    begin
        logic [7:0] corner [3];
        corner[0] = 8'h80;
        corner[1] = 8'h00;
        corner[2] = 8'h7f;
        wave_sb   = new();
        cycles    = 0;
        hold_go   = 1'b0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_SOURCE_X;
        cfg_data  = '0;
        in_valid  = 1'b0;
        pixel_x   = '0;
        pixel_y   = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part under reset settings: corner pixels as one burst.
        foreach (corner[i])
            foreach (corner[j])
                send_pixel(corner[i], corner[j]);
        end_burst(2);

        // Source right at the center with no depth: the center pixel has zero
        // distance, so the phase is the offset alone. Quarter-turn offsets hit
        // the value of one on each output in both signs.
        set_source(32'd0, 32'd0, 32'd0, 32'd0);
        for (int q = 0; q < 4; q++) begin
            write_reg(REG_PHASE_OFFSET, q * 16384);
            send_pixel(8'd0, 8'd0);
            send_pixel(8'd1, 8'hff);
            end_burst(1);
        end
        // Largest offset makes the phase wrap past a full turn.
        write_reg(REG_PHASE_OFFSET, 32'h0000ffff);
        send_pixel(8'd0, 8'd0);
        send_pixel(8'h7f, 8'h80);
        end_burst(1);

        // Extreme source positions and depth.
        set_source(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h0000ffff);
        foreach (corner[i])
            send_pixel(corner[i], corner[2 - i]);
        end_burst(3);

        // Random part, one phase per setting. The long hold-off is started in the
        // first of them while the sender keeps offering items.
        set_source(32'd0, 32'd0, 32'd5000000, 32'd0);
        hold_go = 1'b1;
        random_pixels(320);
        set_source(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h00008000);
        random_pixels(320);
        set_source(32'd0, 32'd0, 32'd0, $urandom_range(0, 65535));
        random_pixels(320);
        for (int p = 0; p < 3; p++) begin
            set_source($urandom, $urandom, $urandom, $urandom);
            random_pixels(320);
        end

        wait_drained();
        repeat (100) @(posedge clk);
        if (wave_sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
